### hdl/keyword_token_lexer_top_macros.svh
// assertion macros for the keyword token lexer
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef KEYWORD_TOKEN_LEXER_TOP_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define KLEX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define KLEX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/klex_pkg.sv
// shared types, token kind codes, keyword table and character classes
// for the keyword token lexer; no dependencies
`default_nettype none

package klex_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WORD  = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_MINUS = 2'd3
  } mode_e;

  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_NUMBER  = 5'd2;
  localparam logic [4:0] KIND_RET     = 5'd3;
  localparam logic [4:0] KIND_LET     = 5'd4;
  localparam logic [4:0] KIND_IF      = 5'd5;
  localparam logic [4:0] KIND_LPAREN  = 5'd6;
  localparam logic [4:0] KIND_RPAREN  = 5'd7;
  localparam logic [4:0] KIND_LBRACE  = 5'd8;
  localparam logic [4:0] KIND_RBRACE  = 5'd9;
  localparam logic [4:0] KIND_ASSIGN  = 5'd10;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_MINUS   = 5'd12;
  localparam logic [4:0] KIND_SLASH   = 5'd14;
  localparam logic [4:0] KIND_GT      = 5'd15;
  localparam logic [4:0] KIND_DEF     = 5'd16;
  localparam logic [4:0] KIND_FUNC    = 5'd17;
  localparam logic [4:0] KIND_MODEL   = 5'd18;
  localparam logic [4:0] KIND_STAR    = 5'd19;
  localparam logic [4:0] KIND_AMP     = 5'd20;
  localparam logic [4:0] KIND_ALLOC   = 5'd21;
  localparam logic [4:0] KIND_SIZEOF  = 5'd22;
  localparam logic [4:0] KIND_COLON   = 5'd23;
  localparam logic [4:0] KIND_ARROW   = 5'd24;
  localparam logic [4:0] KIND_COMMA   = 5'd25;
  localparam logic [4:0] KIND_SPAWN   = 5'd26;
  localparam logic [4:0] KIND_SHARED  = 5'd27;
  localparam logic [4:0] KIND_UNKNOWN = 5'd28;

  localparam int unsigned NUM_KEYWORDS = 10;
  localparam int unsigned KW_BITS      = 48;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // keyword text, first character highest
  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    48'h000000646566, 48'h000066756E63, 48'h006D6F64656C, 48'h0000006C6574,
    48'h000000006966, 48'h000000726574, 48'h00616C6C6F63, 48'h73697A656F66,
    48'h00737061776E, 48'h736861726564
  };
  localparam logic [15:0] KW_LEN [NUM_KEYWORDS] = '{
    16'd3, 16'd4, 16'd5, 16'd3, 16'd2, 16'd3, 16'd5, 16'd6, 16'd5, 16'd6
  };
  localparam logic [4:0] KW_KIND [NUM_KEYWORDS] = '{
    KIND_DEF, KIND_FUNC, KIND_MODEL, KIND_LET, KIND_IF,
    KIND_RET, KIND_ALLOC, KIND_SIZEOF, KIND_SPAWN, KIND_SHARED
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [31:0] value;
  } token_t;

  // all tokens caused by one byte
  typedef struct packed {
    token_t tok_a;
    token_t tok_b;
    logic   two;
  } rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [4:0] symbol_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3E:   k = KIND_GT;
      8'h3D:   k = KIND_ASSIGN;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h26:   k = KIND_AMP;
      8'h3A:   k = KIND_COLON;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### hdl/klex_front.sv
// front end: accepts text bytes, keeps the scanner state and builds the
// token record for each byte; uses klex_pkg
`default_nettype none

module klex_front import klex_pkg::*; #(
  parameter int unsigned POSITION_BITS     = 16,
  parameter int unsigned KEYWORD_MAX_CHARS = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] text_byte_i,
  input  wire q_stat_t    q_stat_i,
  output logic            in_stall_o,
  output logic            push_o,
  output rec_t            rec_o
);

  localparam int unsigned PW = 8 * KEYWORD_MAX_CHARS;

  mode_e                    mode_q, mode_d;
  logic [PW-1:0]            prefix_q, prefix_d;
  logic [15:0]              run_len_q, run_len_d;
  logic [15:0]              run_start_q, run_start_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [31:0]              acc_q, acc_d;

  logic                     accept;
  logic [POSITION_BITS+15:0] pos_ext;
  logic [15:0]              pos16;
  logic [7:0]               c;
  logic [3:0]               dig;
  logic [15:0]              run_len_inc;
  logic [4:0]               word_kind;
  token_t                   t0, t1;
  logic                     t0v, t1v, taken;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign c          = text_byte_i;
  assign dig        = c[3:0];
  assign pos_ext    = {16'b0, pos_q};
  assign pos16      = pos_ext[15:0];
  assign run_len_inc = (run_len_q != LEN_MAX) ? run_len_q + 16'd1 : run_len_q;

  always_comb begin
    word_kind = KIND_IDENT;
    if (run_len_q <= 16'(KEYWORD_MAX_CHARS)) begin
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
        if (run_len_q == KW_LEN[i] && prefix_q == PW'(KW_TEXT[i])) begin
          word_kind = KW_KIND[i];
        end
      end
    end
  end

  always_comb begin
    mode_d      = mode_q;
    prefix_d    = prefix_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    t0          = '0;
    t1          = '0;
    t0v         = 1'b0;
    t1v         = 1'b0;
    taken       = 1'b0;

    // flush or extend the pending run
    unique case (mode_q)
      MODE_IDLE: begin
      end
      MODE_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          if (run_len_q < 16'(KEYWORD_MAX_CHARS)) begin
            prefix_d = {prefix_q[PW-9:0], c};
          end
          run_len_d = run_len_inc;
          taken     = 1'b1;
        end else begin
          t0v    = 1'b1;
          t0     = '{kind: word_kind, start: run_start_q, length: run_len_q, value: 32'd0};
          mode_d = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (is_digit(c)) begin
          acc_d     = {acc_q[28:0], 3'b0} + {acc_q[30:0], 1'b0} + {28'b0, dig};
          run_len_d = run_len_inc;
          taken     = 1'b1;
        end else begin
          t0v    = 1'b1;
          t0     = '{kind: KIND_NUMBER, start: run_start_q, length: run_len_q,
                     value: acc_q};
          mode_d = MODE_IDLE;
        end
      end
      MODE_MINUS: begin
        mode_d = MODE_IDLE;
        t0v    = 1'b1;
        if (c == 8'h3E) begin
          t0    = '{kind: KIND_ARROW, start: run_start_q, length: 16'd2, value: 32'd0};
          taken = 1'b1;
        end else begin
          t0 = '{kind: KIND_MINUS, start: run_start_q, length: 16'd1, value: 32'd0};
        end
      end
      default: begin
      end
    endcase

    // the byte on its own
    if (!taken) begin
      if (c == 8'h00) begin
        t1v = 1'b1;
        t1  = '{kind: KIND_EOF, start: pos16, length: 16'd0, value: 32'd0};
      end else if (is_space(c)) begin
      end else if (is_letter(c)) begin
        mode_d      = MODE_WORD;
        prefix_d    = PW'(c);
        run_start_d = pos16;
        run_len_d   = 16'd1;
      end else if (is_digit(c)) begin
        mode_d      = MODE_NUM;
        acc_d       = {28'b0, dig};
        run_start_d = pos16;
        run_len_d   = 16'd1;
      end else if (c == 8'h2D) begin
        mode_d      = MODE_MINUS;
        run_start_d = pos16;
        run_len_d   = 16'd1;
      end else begin
        t1v = 1'b1;
        t1  = '{kind: symbol_kind(c), start: pos16, length: 16'd1, value: 32'd0};
      end
    end

    if (c == 8'h00) begin
      mode_d      = MODE_IDLE;
      prefix_d    = '0;
      run_len_d   = '0;
      run_start_d = '0;
      acc_d       = '0;
      pos_d       = '0;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_comb begin
    push_o = accept && (t0v || t1v);
    if (t0v) begin
      rec_o = '{tok_a: t0, tok_b: t1, two: t1v};
    end else begin
      rec_o = '{tok_a: t1, tok_b: t1, two: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      prefix_q    <= '0;
      run_len_q   <= '0;
      run_start_q <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
    end else if (accept) begin
      mode_q      <= mode_d;
      prefix_q    <= prefix_d;
      run_len_q   <= run_len_d;
      run_start_q <= run_start_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
    end
  end

endmodule

`default_nettype wire

### hdl/klex_queue.sv
// short queue of token records between front and back end
// uses klex_pkg
`default_nettype none

module klex_queue import klex_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire rec_t  rec_i,
  input  wire logic  pop_i,
  output rec_t       head_o,
  output q_stat_t    stat_o
);

  rec_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### hdl/klex_back.sv
// back end: splits records into single tokens and holds the output register
// uses klex_pkg
`default_nettype none

module klex_back import klex_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire rec_t  head_i,
  input  wire q_stat_t q_stat_i,
  input  wire logic  out_stall_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output token_t     tok_o,
  output logic       last_o
);

  logic   out_valid_q, out_valid_d;
  token_t tok_q, tok_d;
  logic   last_q, last_d;
  logic   sel_q, sel_d;
  logic   load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    tok_d       = tok_q;
    last_d      = last_q;
    sel_d       = sel_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        tok_d  = sel_q ? head_i.tok_b : head_i.tok_a;
        last_d = sel_q || !head_i.two;
        if (head_i.two && !sel_q) begin
          sel_d = 1'b1;
        end else begin
          sel_d = 1'b0;
          pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tok_o       = tok_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### hdl/keyword_token_lexer_top.sv
// keyword token lexer top level: front end, record queue, back end
// uses klex_pkg, klex_front, klex_queue, klex_back and the macro header
//
//  channel  | direction | handshake              | payload
//  text in  | input     | in_valid_i / in_stall_o | text_byte_i
//  token out| output    | out_valid_o / out_stall_i | token_kind_o, token_start_o,
//           |           |                        | token_length_o, number_value_o,
//           |           |                        | last_of_run_o
//
// one byte per cycle is taken while the four-entry record queue has room
// tokens leave one per cycle from the output register while out_stall_i is low; a byte that causes
// two tokens sends them out one after the other, the only cause of in_stall_o besides out_stall_i
// a byte's first token goes through the queue memory and then the output register
// reset clears scanner state, queue pointers and output valid; payload is not reset
`default_nettype none

`include "keyword_token_lexer_top_macros.svh"

module keyword_token_lexer_top import klex_pkg::*; #(
  parameter int unsigned POSITION_BITS     = 16,
  parameter int unsigned KEYWORD_MAX_CHARS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       token_kind_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic [31:0]      number_value_o,
  output logic             last_of_run_o
);

  q_stat_t q_stat;
  rec_t    q_in, q_head;
  logic    q_push, q_pop;
  token_t  tok;

  klex_front #(
    .POSITION_BITS     (POSITION_BITS),
    .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .text_byte_i (text_byte_i),
    .q_stat_i    (q_stat),
    .in_stall_o  (in_stall_o),
    .push_o      (q_push),
    .rec_o       (q_in)
  );

  klex_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .rec_i  (q_in),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  klex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_stat_i    (q_stat),
    .out_stall_i (out_stall_i),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;
  assign number_value_o = tok.value;

  `KLEX_ASSERT(a_pop_not_empty, !q_pop || !q_stat.empty, "pop from empty queue")
  `KLEX_ASSERT(a_eof_shape, !(out_valid_o && token_kind_o == KIND_EOF) || (token_length_o == 16'd0 && last_of_run_o), "bad end-of-text token")
  `KLEX_ASSERT(a_value_only_number, !(out_valid_o && token_kind_o != KIND_NUMBER) || number_value_o == 32'd0, "value on non-number token")
  `KLEX_ASSERT_NEXT(a_second_follows, out_valid_o && !out_stall_i && !last_of_run_o, out_valid_o, "second token of a byte missing")

endmodule

`default_nettype wire

### verif/lex_check_pkg.sv
// scoreboard for the keyword token lexer: predicts the tokens that each text
// byte causes and checks the output transactions in order
// depends on klex_pkg for the token kind codes and the scan mode enum
package lex_check_pkg;
  import klex_pkg::*;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [31:0] value;
    logic        last;
  } lex_token_t;

  class token_scoreboard;
    mode_e       mode;
    logic [47:0] prefix;
    logic [15:0] run_len;
    logic [15:0] run_pos;
    logic [15:0] text_pos;
    logic [31:0] acc;
    lex_token_t  expected_q[$];
    int unsigned checked;
    int unsigned errors;

    function new();
      clear_scan();
      text_pos = '0;
      checked  = 0;
      errors   = 0;
    endfunction

    function void clear_scan();
      mode    = MODE_IDLE;
      prefix  = '0;
      run_len = '0;
      run_pos = '0;
      acc     = '0;
    endfunction

    function logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function lex_token_t mk(logic [4:0] kind, logic [15:0] start, logic [15:0] length,
                            logic [31:0] value);
      lex_token_t t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.value  = value;
      t.last   = 1'b0;
      return t;
    endfunction

    function void note_byte(logic [7:0] c);
      lex_token_t  made[$];
      logic [15:0] pos;
      logic [4:0]  k;
      bit          taken;
      pos   = text_pos;
      taken = 1'b0;
      case (mode)
        MODE_WORD: begin
          if (is_alpha(c) || is_num(c)) begin
            if (run_len < 16'd6) prefix = {prefix[39:0], c};
            if (run_len != 16'hFFFF) run_len++;
            taken = 1'b1;
          end else begin
            k = KIND_IDENT;
            if (run_len <= 16'd6) begin
              case (prefix)
                "def":    k = KIND_DEF;
                "func":   k = KIND_FUNC;
                "model":  k = KIND_MODEL;
                "let":    k = KIND_LET;
                "if":     k = KIND_IF;
                "ret":    k = KIND_RET;
                "alloc":  k = KIND_ALLOC;
                "sizeof": k = KIND_SIZEOF;
                "spawn":  k = KIND_SPAWN;
                "shared": k = KIND_SHARED;
                default:  k = KIND_IDENT;
              endcase
            end
            made.push_back(mk(k, run_pos, run_len, 32'd0));
            mode = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (is_num(c)) begin
            acc = acc * 32'd10 + ({24'd0, c} - 32'd48);
            if (run_len != 16'hFFFF) run_len++;
            taken = 1'b1;
          end else begin
            made.push_back(mk(KIND_NUMBER, run_pos, run_len, acc));
            mode = MODE_IDLE;
          end
        end
        MODE_MINUS: begin
          mode = MODE_IDLE;
          if (c == ">") begin
            made.push_back(mk(KIND_ARROW, run_pos, 16'd2, 32'd0));
            taken = 1'b1;
          end else begin
            made.push_back(mk(KIND_MINUS, run_pos, 16'd1, 32'd0));
          end
        end
        default: ;
      endcase

      if (!taken) begin
        if (c == 8'h00) begin
          made.push_back(mk(KIND_EOF, pos, 16'd0, 32'd0));
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
          // whitespace only moves the position
        end else if (is_alpha(c)) begin
          mode    = MODE_WORD;
          prefix  = {40'd0, c};
          run_pos = pos;
          run_len = 16'd1;
        end else if (is_num(c)) begin
          mode    = MODE_NUM;
          acc     = {24'd0, c} - 32'd48;
          run_pos = pos;
          run_len = 16'd1;
        end else if (c == "-") begin
          mode    = MODE_MINUS;
          run_pos = pos;
          run_len = 16'd1;
        end else begin
          case (c)
            "+":     k = KIND_PLUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            ">":     k = KIND_GT;
            "=":     k = KIND_ASSIGN;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "&":     k = KIND_AMP;
            ":":     k = KIND_COLON;
            ",":     k = KIND_COMMA;
            default: k = KIND_UNKNOWN;
          endcase
          made.push_back(mk(k, pos, 16'd1, 32'd0));
        end
      end

      if (c == 8'h00) begin
        clear_scan();
        text_pos = '0;
      end else begin
        text_pos = pos + 16'd1;
      end

      if (made.size() != 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) expected_q.push_back(made[i]);
    endfunction

    function void check_token(lex_token_t got);
      lex_token_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token: kind %0d start %0d length %0d value %0d last %0b",
                   got.kind, got.start, got.length, got.value, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("token mismatch: expected kind %0d start %0d length %0d value %0d last %0b",
                   want.kind, want.start, want.length, want.value, want.last);
          $display("                actual   kind %0d start %0d length %0d value %0d last %0b",
                   got.kind, got.start, got.length, got.value, got.last);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### verif/tb_keyword_token_lexer_top.sv
// self-checking testbench for keyword_token_lexer_top: sends text bytes with
// random gaps, stalls the token side at random and checks every transaction
// depends on klex_pkg, lex_check_pkg and the lexer RTL
module tb_keyword_token_lexer_top;
  import klex_pkg::*;
  import lex_check_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned LONG_WORD      = 40;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  tok_kind;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [31:0] tok_value;
  logic        tok_last;

  token_scoreboard sb;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned live_bytes  = 0;
  int unsigned total_bytes = 0;

  string kw_words[10] = '{"def", "func", "model", "let", "if",
                          "ret", "alloc", "sizeof", "spawn", "shared"};
  string sym_chars = "+*/>=(){}&:,-";

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  keyword_token_lexer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .text_byte_i    (text_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (tok_kind),
    .token_start_o  (tok_start),
    .token_length_o (tok_len),
    .number_value_o (tok_value),
    .last_of_run_o  (tok_last)
  );

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(9) < 7) ? rand_letter() : 8'h30 + 8'($urandom_range(9));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!tx_calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_byte(b);
    total_bytes++;
    if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))) live_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_random_token();
    int unsigned pick;
    int unsigned len;
    int unsigned shape;
    string       w;
    pick = $urandom_range(99);
    if (pick < 22) begin
      // keywords, some cut short or run on into an identifier
      w     = kw_words[$urandom_range(9)];
      len   = w.len();
      shape = $urandom_range(7);
      if (shape == 0) len--;
      for (int i = 0; i < len; i++) send_byte(w[i]);
      if (shape == 1) send_byte(rand_alnum());
      if ($urandom_range(3) != 0) send_byte(8'h20);
    end else if (pick < 40) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 7);
      send_byte(rand_letter());
      repeat (len - 1) send_byte(rand_alnum());
    end else if (pick < 55) begin
      len = $urandom_range(1, 12);
      repeat (len) send_byte(8'h30 + 8'($urandom_range(9)));
    end else if (pick < 75) begin
      len = $urandom_range(sym_chars.len());
      if (len == sym_chars.len()) send_text("->");
      else send_byte(sym_chars[len]);
    end else if (pick < 85) begin
      len = $urandom_range(6);
      send_byte((len == 6) ? 8'h20 : 8'h09 + 8'(len));
    end else if (pick < 88) begin
      send_byte(8'h00);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // token side: check accepted transactions, then decide the next stall
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall)
        sb.check_token(lex_token_t'{tok_kind, tok_start, tok_len, tok_value, tok_last});
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 59;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !rx_calm && ($urandom_range(99) < 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned base;
    int unsigned n;
    bit          hold_done;
    bit          pause_done;
    sb = new();
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keyword, lone minus, arrow, unknown bytes, flush by zero, repeated zeros
    send_text("if");
    send_text("-x");
    send_text("->");
    send_byte("9");
    send_byte(")");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'h09);
    send_byte("a");
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte("7");
    send_byte(8'h00);
    send_byte("-");
    send_byte(8'h00);

    // word far longer than any keyword, then a number
    send_byte(8'h20);
    send_byte(rand_letter());
    repeat (LONG_WORD - 1) send_byte(rand_alnum());
    send_text(" 12 ");
    wait_drained();

    base = live_bytes;
    while (live_bytes < base + RANDOM_ITEMS) begin
      n       = live_bytes - base;
      tx_calm = (n >= 300 && n < 500) || (n >= 600 && n < 650);
      rx_calm = (n >= 300 && n < 500);
      if (n >= 600 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (n >= 900 && !pause_done) begin
        wait_drained();
        pause_done = 1'b1;
      end
      send_random_token();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("sent %0d text bytes, checked %0d token transactions, %0d errors",
             total_bytes, sb.checked, sb.errors);
    $display("covered keywords, words, numbers, symbols, arrows, zero and unknown bytes,");
    $display("a long word, a long output hold with a full queue and a drain");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
